// ----- hdl/urbf_pkg.sv -----
// urbf_pkg: shared constants and sizes of the uart register block
// no dependencies; imported by the channel interfaces, the core and the checker
`timescale 1ns / 1ps

package urbf_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;

   localparam int OP_W   = 2;
   localparam int SEL_W  = 4;
   localparam int DATA_W = 16;
   localparam int BYTE_W = 8;

   // op codes
   localparam logic [OP_W-1:0] OP_BUS_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUS_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_LINE_RX   = 2'd2;
   localparam logic [OP_W-1:0] OP_LINE_TX   = 2'd3;

   // register selects
   localparam logic [SEL_W-1:0] SEL_DATA   = 4'd0;
   localparam logic [SEL_W-1:0] SEL_FLAGS  = 4'd1;
   localparam logic [SEL_W-1:0] SEL_IBRD   = 4'd2;
   localparam logic [SEL_W-1:0] SEL_FBRD   = 4'd3;
   localparam logic [SEL_W-1:0] SEL_LCR    = 4'd4;
   localparam logic [SEL_W-1:0] SEL_CTRL   = 4'd5;
   localparam logic [SEL_W-1:0] SEL_MASK   = 4'd6;
   localparam logic [SEL_W-1:0] SEL_MIS    = 4'd7;
   localparam logic [SEL_W-1:0] SEL_CLEAR  = 4'd8;

   // register widths
   localparam int FBRD_W = 6;
   localparam int LCR_W  = 8;
   localparam int MASK_W = 11;

   // bit positions
   localparam int FLAG_TXFE_BIT = 7;
   localparam int FLAG_RXFF_BIT = 6;
   localparam int FLAG_TXFF_BIT = 5;
   localparam int FLAG_RXFE_BIT = 4;
   localparam int FLAG_BUSY_BIT = 3;
   localparam int CTRL_EN_BIT   = 0;
   localparam int CTRL_TXE_BIT  = 8;
   localparam int CTRL_RXE_BIT  = 9;
   localparam int INT_RX_BIT    = 4;

   localparam logic [DATA_W-1:0] CTRL_RESET = 16'h0300;

endpackage

// ----- hdl/urbf_if.sv -----
// urbf_req_if, urbf_rsp_if: valid/ready channels of the uart register block
// depends on urbf_pkg
`timescale 1ns / 1ps

interface urbf_req_if;
   import urbf_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [SEL_W-1:0]  reg_select;
   logic [DATA_W-1:0] write_data;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, op, reg_select, write_data, rx_byte, input ready);
   modport sink   (input valid, op, reg_select, write_data, rx_byte, output ready);
endinterface

interface urbf_rsp_if;
   import urbf_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              tx_valid;
   logic [BYTE_W-1:0] tx_byte;
   logic              irq;

   modport source (output valid, read_data, tx_valid, tx_byte, irq, input ready);
   modport sink   (input valid, read_data, tx_valid, tx_byte, irq, output ready);
endinterface

// ----- hdl/uart_register_block_with_fifos_core.sv -----
// uart_register_block_with_fifos_core: register side of a uart with tx and rx fifos
// depends on urbf_pkg, urbf_req_if/urbf_rsp_if and urbf_ram
//
//   channel   dir   words carried
//   req_ch    in    op, reg_select, write_data, rx_byte
//   rsp_ch    out   read_data, tx_valid, tx_byte, irq
//
// one word per cycle while rsp_ch is not stalled; a result appears in the cycle after its word is taken
// counts, pointers and registers update at accept; fifo bytes come from the
// registered ram read port, loaded at the pop. no clearing pass after reset.
// req_ch.ready drops only while a result waits on a stalled rsp_ch
`timescale 1ns / 1ps

module uart_register_block_with_fifos_core (
   input logic        clock,
   input logic        reset,
   urbf_req_if.sink   req_ch,
   urbf_rsp_if.source rsp_ch
);
   import urbf_pkg::*;

   logic [CNT_W-1:0]  tx_count_ff, tx_count_in, rx_count_ff, rx_count_in;
   logic [PTR_W-1:0]  tx_ptr_ff, tx_ptr_in, rx_ptr_ff, rx_ptr_in;
   logic [DATA_W-1:0] ctrl_ff, ctrl_in, ibrd_ff, ibrd_in;
   logic [FBRD_W-1:0] fbrd_ff, fbrd_in;
   logic [LCR_W-1:0]  lcr_ff, lcr_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              raw_ff, raw_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              out_rx_ff, out_rx_in;
   logic              out_tx_ff, out_tx_in;
   logic              out_irq_ff, out_irq_in;

   logic              fire;
   logic              tx_en, rx_en;
   logic              tx_push, tx_pop, rx_push, rx_pop;
   logic [PTR_W-1:0]  tx_wr_addr, rx_wr_addr;
   logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;
   logic [DATA_W-1:0] flags, rd_value;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] wr_slot(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + SUM_W'(c);
      if (s >= SUM_W'(FIFO_DEPTH)) begin
         s = s - SUM_W'(FIFO_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   assign fire         = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;

   assign tx_en = ctrl_ff[CTRL_EN_BIT] && ctrl_ff[CTRL_TXE_BIT];
   assign rx_en = ctrl_ff[CTRL_EN_BIT] && ctrl_ff[CTRL_RXE_BIT];

   assign tx_push = fire && req_ch.op == OP_BUS_WRITE && req_ch.reg_select == SEL_DATA
                    && tx_en && tx_count_ff < CNT_W'(FIFO_DEPTH);
   assign tx_pop  = fire && req_ch.op == OP_LINE_TX && tx_en && tx_count_ff != '0;
   assign rx_push = fire && req_ch.op == OP_LINE_RX && rx_en
                    && rx_count_ff < CNT_W'(FIFO_DEPTH);
   assign rx_pop  = fire && req_ch.op == OP_BUS_READ && req_ch.reg_select == SEL_DATA
                    && rx_count_ff != '0;

   assign tx_wr_addr = wr_slot(tx_ptr_ff, tx_count_ff);
   assign rx_wr_addr = wr_slot(rx_ptr_ff, rx_count_ff);

   // one op per word, so a push and a pop never hit the same fifo in one cycle
   urbf_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_push),
      .wr_addr (tx_wr_addr),
      .wr_data (req_ch.write_data[BYTE_W-1:0]),
      .rd_en   (tx_pop),
      .rd_addr (tx_ptr_ff),
      .rd_data (tx_rd_data)
   );

   urbf_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_push),
      .wr_addr (rx_wr_addr),
      .wr_data (req_ch.rx_byte),
      .rd_en   (rx_pop),
      .rd_addr (rx_ptr_ff),
      .rd_data (rx_rd_data)
   );

   always_comb begin
      flags = '0;
      flags[FLAG_TXFE_BIT] = (tx_count_ff == '0);
      flags[FLAG_RXFF_BIT] = (rx_count_ff >= CNT_W'(FIFO_DEPTH));
      flags[FLAG_TXFF_BIT] = (tx_count_ff >= CNT_W'(FIFO_DEPTH));
      flags[FLAG_RXFE_BIT] = (rx_count_ff == '0);
      flags[FLAG_BUSY_BIT] = (tx_count_ff != '0);
   end

   always_comb begin
      rd_value = '0;
      unique case (req_ch.reg_select)
         SEL_FLAGS: rd_value = flags;
         SEL_IBRD:  rd_value = ibrd_ff;
         SEL_FBRD:  rd_value = DATA_W'(fbrd_ff);
         SEL_LCR:   rd_value = DATA_W'(lcr_ff);
         SEL_CTRL:  rd_value = ctrl_ff;
         SEL_MASK:  rd_value = DATA_W'(mask_ff);
         SEL_MIS:   rd_value[INT_RX_BIT] = raw_ff && mask_ff[INT_RX_BIT];
         default:   rd_value = '0;
      endcase
   end

   always_comb begin
      tx_count_in  = tx_count_ff;
      rx_count_in  = rx_count_ff;
      tx_ptr_in    = tx_ptr_ff;
      rx_ptr_in    = rx_ptr_ff;
      ctrl_in      = ctrl_ff;
      ibrd_in      = ibrd_ff;
      fbrd_in      = fbrd_ff;
      lcr_in       = lcr_ff;
      mask_in      = mask_ff;
      raw_in       = raw_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_data_in  = out_data_ff;
      out_rx_in    = out_rx_ff;
      out_tx_in    = out_tx_ff;
      out_irq_in   = out_irq_ff;

      if (tx_push) begin
         tx_count_in = tx_count_ff + 1'b1;
      end
      if (tx_pop) begin
         tx_count_in = tx_count_ff - 1'b1;
         tx_ptr_in   = ptr_inc(tx_ptr_ff);
      end
      if (rx_push) begin
         rx_count_in = rx_count_ff + 1'b1;
      end
      if (rx_pop) begin
         rx_count_in = rx_count_ff - 1'b1;
         rx_ptr_in   = ptr_inc(rx_ptr_ff);
      end

      if (fire) begin
         unique case (req_ch.op)
            OP_BUS_READ:  ;
            OP_BUS_WRITE: begin
               unique case (req_ch.reg_select)
                  SEL_IBRD:  ibrd_in = req_ch.write_data;
                  SEL_FBRD:  fbrd_in = req_ch.write_data[FBRD_W-1:0];
                  SEL_LCR:   lcr_in  = req_ch.write_data[LCR_W-1:0];
                  SEL_CTRL:  ctrl_in = req_ch.write_data;
                  SEL_MASK:  mask_in = req_ch.write_data[MASK_W-1:0];
                  SEL_CLEAR: if (req_ch.write_data[INT_RX_BIT]) raw_in = 1'b0;
                  default:   ;
               endcase
            end
            OP_LINE_RX:   if (rx_en) raw_in = 1'b1;
            OP_LINE_TX:   ;
         endcase

         out_valid_in = 1'b1;
         out_data_in  = (req_ch.op == OP_BUS_READ) ? rd_value : '0;
         out_rx_in    = rx_pop;
         out_tx_in    = tx_pop;
         out_irq_in   = raw_in && mask_in[INT_RX_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_count_ff  <= '0;
         rx_count_ff  <= '0;
         tx_ptr_ff    <= '0;
         rx_ptr_ff    <= '0;
         ctrl_ff      <= CTRL_RESET;
         ibrd_ff      <= '0;
         fbrd_ff      <= '0;
         lcr_ff       <= '0;
         mask_ff      <= '0;
         raw_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tx_count_ff  <= tx_count_in;
         rx_count_ff  <= rx_count_in;
         tx_ptr_ff    <= tx_ptr_in;
         rx_ptr_ff    <= rx_ptr_in;
         ctrl_ff      <= ctrl_in;
         ibrd_ff      <= ibrd_in;
         fbrd_ff      <= fbrd_in;
         lcr_ff       <= lcr_in;
         mask_ff      <= mask_in;
         raw_ff       <= raw_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_rx_ff   <= out_rx_in;
      out_tx_ff   <= out_tx_in;
      out_irq_ff  <= out_irq_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.read_data = out_rx_ff ? DATA_W'(rx_rd_data) : out_data_ff;
   assign rsp_ch.tx_valid  = out_tx_ff;
   assign rsp_ch.tx_byte   = out_tx_ff ? tx_rd_data : '0;
   assign rsp_ch.irq       = out_irq_ff;

endmodule

// ----- hdl/urbf_ram.sv -----
// urbf_ram: generic single-clock ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module urbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/urbf_checker.sv -----
// urbf_checker: port-level assertions for the uart register block, bound to the top
// depends on urbf_pkg and uart_register_block_with_fifos_core
`timescale 1ns / 1ps

module urbf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [urbf_pkg::DATA_W-1:0] rsp_read_data,
   input logic                      rsp_tx_valid,
   input logic [urbf_pkg::BYTE_W-1:0] rsp_tx_byte
);
   import urbf_pkg::*;

   // a taken word yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("result missing after accepted word");

   // no new word while a result is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("word taken while result stalled");

   // a drained byte never comes with read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> rsp_read_data == '0)
      else $error("read data alongside transmit byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == '0)
      else $error("transmit byte without tx_valid");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                  && $stable(rsp_tx_byte))
      else $error("stalled result changed");

endmodule

bind uart_register_block_with_fifos_core urbf_checker u_urbf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_tx_valid  (rsp_ch.tx_valid),
   .rsp_tx_byte   (rsp_ch.tx_byte)
);
